/* src/rde_pkg.sv */
// shared types, constants and digit table for the radix digit emitter
`timescale 1ns / 1ps
package rde_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [4:0] RADIX_MIN = 5'd3;
    localparam logic [4:0] RADIX_MAX = 5'd16;

    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  radix;
        logic        signed_mode;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [4:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [3:0]  remainder;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } t_state;

endpackage

/* src/rde_divider.sv */
// iterative divider: 64-bit dividend by a small base, one byte per cycle
`timescale 1ns / 1ps
module rde_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rde_pkg::t_div_req i_req,
    output rde_pkg::t_div_rsp o_rsp
);
    import rde_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_work, n_work;
    logic [3:0]  r_rem, n_rem;
    logic [4:0]  r_div, n_div;

    logic [7:0]  cur_byte;
    logic [7:0]  q_byte;
    logic [3:0]  rem_acc;
    logic [4:0]  trial;
    logic [2:0]  top_idx;

    // highest nonzero byte; zero bytes above it give zero quotient bytes
    always_comb begin
        top_idx = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (|i_req.dividend[k*8 +: 8]) begin
                top_idx = k[2:0];
            end
        end
    end

    // eight restoring steps on the current byte
    always_comb begin
        cur_byte = r_work[{r_idx, 3'b000} +: 8];
        rem_acc  = r_rem;
        q_byte   = 8'd0;
        trial    = 5'd0;
        for (int b = 7; b >= 0; b--) begin
            trial = {rem_acc, cur_byte[b]};
            if (trial >= r_div) begin
                q_byte[b] = 1'b1;
                rem_acc   = 4'(trial - r_div);
            end else begin
                rem_acc = trial[3:0];
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_idx  = r_idx;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_idx  = top_idx;
            n_work = i_req.dividend;
            n_rem  = 4'd0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_work[{r_idx, 3'b000} +: 8] = q_byte;
            n_rem = rem_acc;
            if (r_idx == 3'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx  <= n_idx;
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work;
    assign o_rsp.remainder = r_rem;

endmodule

/* src/rde_digit_buf.sv */
// digit store, written least significant first and read back in reverse
`timescale 1ns / 1ps
module rde_digit_buf (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rde_pkg::ADDR_W-1:0] i_waddr,
    input  logic [3:0]                 i_wdata,
    input  logic [rde_pkg::ADDR_W-1:0] i_raddr,
    output logic [3:0]                 o_rdata
);
    import rde_pkg::*;

    logic [3:0] r_mem [MAX_DIGITS];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/radix_digit_emitter.sv */
// radix digit emitter: 64-bit number to ascii text in base 3 to 16
// sequence: each digit costs one division in the shared divider, over the bytes of
// the remaining magnitude from its highest nonzero byte down (1 to 8 bytes); then
// each character out is read and loaded, after a leading minus sign if negative
// throughput: one item at a time, ready again once the last character is loaded
// reset: synchronous active low, clears the sequencer, divider and output valid
`timescale 1ns / 1ps
module radix_digit_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rde_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rde_pkg::t_out o_data
);
    import rde_pkg::*;

    t_state r_state, n_state;

    logic [63:0]       r_mag;
    logic              r_neg;
    logic [4:0]        r_base;
    logic [CNT_W-1:0]  r_nd;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_ovalid;
    t_out              r_odata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic [3:0]        rd_digit;

    logic              in_acc;
    logic              out_free;
    logic              finish;
    logic              dig_we;
    logic              ld_sign;
    logic              ld_digit;
    logic [4:0]        base_clamped;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign finish   = (div_rsp.quotient == 64'd0) ||
                      (r_nd == CNT_W'(MAX_DIGITS - 1));

    always_comb begin
        if (i_data.radix < RADIX_MIN) begin
            base_clamped = RADIX_MIN;
        end else if (i_data.radix > RADIX_MAX) begin
            base_clamped = RADIX_MAX;
        end else begin
            base_clamped = i_data.radix;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_START;
            end
            ST_START: n_state = ST_WAIT;
            ST_WAIT: begin
                if (div_rsp.done) begin
                    if (finish) n_state = r_neg ? ST_SIGN : ST_READ;
                    else        n_state = ST_START;
                end
            end
            ST_SIGN: begin
                if (out_free) n_state = ST_READ;
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (out_free) n_state = (r_ptr == '0) ? ST_IDLE : ST_READ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        div_req.start    = (r_state == ST_START);
        div_req.dividend = r_mag;
        div_req.divisor  = r_base;
        dig_we           = (r_state == ST_WAIT) && div_rsp.done;
        ld_sign          = (r_state == ST_SIGN) && out_free;
        ld_digit         = (r_state == ST_LOAD) && out_free;
    end

    rde_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rde_digit_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_nd[ADDR_W-1:0]),
        .i_wdata (div_rsp.remainder),
        .i_raddr (r_ptr),
        .o_rdata (rd_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_sign || ld_digit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end

        if (in_acc) begin
            // magnitude of a negative signed value, most negative included
            r_neg  <= i_data.signed_mode && i_data.value[63];
            r_mag  <= (i_data.signed_mode && i_data.value[63]) ?
                      (~i_data.value + 64'd1) : i_data.value;
            r_base <= base_clamped;
            r_nd   <= '0;
        end else if (dig_we) begin
            r_mag <= div_rsp.quotient;
            r_nd  <= r_nd + CNT_W'(1);
            r_ptr <= r_nd[ADDR_W-1:0];
        end else if (ld_digit && (r_ptr != '0)) begin
            r_ptr <= r_ptr - ADDR_W'(1);
        end

        if (ld_sign) begin
            r_odata.character <= CH_MINUS;
            r_odata.last      <= 1'b0;
        end else if (ld_digit) begin
            r_odata.character <= DIGIT_CHARS[rd_digit];
            r_odata.last      <= (r_ptr == '0);
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

/* src/rde_checker.sv */
// port-level checks for the radix digit emitter, bound to the top level
`timescale 1ns / 1ps
module rde_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input rde_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input rde_pkg::t_out o_data
);
    import rde_pkg::*;

    // an item is open from its acceptance until its last character shows
    logic r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_open <= 1'b1;
        end else if (o_valid && o_data.last) begin
            r_open <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output item changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted item");

    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> !r_open || (o_valid && o_data.last))
        else $error("new item taken before the last character of the previous one");

    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.character == CH_MINUS && !o_data.last) ||
                    (o_data.character >= 8'h30 && o_data.character <= 8'h39) ||
                    (o_data.character >= 8'h41 && o_data.character <= 8'h46))
        else $error("character outside the digit set");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

/* test/rde_checker.sv */
// item checker for the radix digit emitter: predicts the text of each number and compares
`timescale 1ns / 1ps
module rde_tb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  rde_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  rde_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import rde_pkg::*;

    t_out expected_chars[$];
    int   mismatches = 0;

    // queue up the characters one number should produce, sign first
    function automatic void spell_number(input t_in item);
        logic [4:0]  base;
        logic [63:0] mag;
        logic [63:0] rem;
        logic        neg;
        logic [7:0]  digs[$];
        t_out        ch;
        base = item.radix;
        if (base < RADIX_MIN) base = RADIX_MIN;
        if (base > RADIX_MAX) base = RADIX_MAX;
        neg = item.signed_mode && item.value[63];
        mag = neg ? (~item.value) + 64'd1 : item.value;
        if (mag == 64'd0) begin
            digs.push_front(DIGIT_CHARS[0]);
        end else begin
            while (mag != 64'd0 && digs.size() < MAX_DIGITS) begin
                rem = mag % base;
                mag = mag / base;
                digs.push_front(DIGIT_CHARS[rem[3:0]]);
            end
        end
        if (neg) begin
            ch.character = CH_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        foreach (digs[i]) begin
            ch.character = digs[i];
            ch.last      = (i == digs.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            // outputs first so a character never matches the number accepted on the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected character %h last %b", $realtime,
                                 i_out_data.character, i_out_data.last);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.character !== i_out_data.character || want.last !== i_out_data.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t: char exp %h got %h, last exp %b got %b", $realtime,
                                     want.character, i_out_data.character, want.last,
                                     i_out_data.last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                spell_number(i_in_data);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_chars.size();
    end

endmodule

/* test/tb_top.sv */
// testbench top for the radix digit emitter: clock, reset, number items and verdict
`timescale 1ns / 1ps
module tb_top;
    import rde_pkg::*;

    localparam int RANDOM_ITEMS   = 235;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 600;
    localparam int STALL_LIMIT    = 5000;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_in   i_data  = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_out  o_data;

    int    fail_count;
    int    pending;
    int    sent = 0;
    int    idle_cycles = 0;
    logic  quiet = 1'b0;
    logic  holdoff_req = 1'b0;

    radix_digit_emitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    rde_tb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one number, with random gaps unless in the quiet stretch
    task automatic offer_number(input logic [63:0] value, input logic [4:0] radix,
                                input logic sgn);
        t_in item;
        item.value       = value;
        item.radix       = radix;
        item.signed_mode = sgn;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 38) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        sent = sent + 1;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 4))
            0, 1: v = {$urandom(), $urandom()};
            2:    v = 64'($urandom_range(0, 1000));
            3:    v = -(64'($urandom_range(1, 1000)));
            default: begin
                v = 64'd1 << k;
                if ($urandom_range(0, 1)) v = v - 64'd1;
            end
        endcase
        return v;
    endfunction

    // receiver side: random stalls, one long hold-off while the sender keeps offering
    initial begin
        logic done_holdoff;
        done_holdoff = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holdoff_req && !done_holdoff) begin
                i_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                done_holdoff = 1'b1;
            end else begin
                i_ready <= quiet || ($urandom_range(0, 99) >= 38);
                @(posedge i_clk);
            end
        end
    end

    // nothing accepted on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [4:0] r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, extremes, the most negative value and out-of-range bases
        offer_number(64'd0, 5'd10, 1'b0);
        offer_number(64'd0, 5'd10, 1'b1);
        offer_number('1, 5'd3, 1'b0);
        offer_number('1, 5'd10, 1'b1);
        offer_number(64'h8000_0000_0000_0000, 5'd10, 1'b1);
        offer_number(64'h8000_0000_0000_0000, 5'd3, 1'b1);
        offer_number(64'h8000_0000_0000_0000, 5'd16, 1'b0);
        offer_number(64'h7FFF_FFFF_FFFF_FFFF, 5'd16, 1'b1);
        offer_number(64'd1234567890, 5'd0, 1'b0);
        offer_number(64'd255, 5'd1, 1'b1);
        offer_number(64'd255, 5'd2, 1'b0);
        offer_number(64'hDEAD_BEEF_0123_4567, 5'd17, 1'b0);
        offer_number(64'hFEDC_BA98_7654_3210, 5'd31, 1'b1);
        for (int b = 4; b <= 15; b++)
            offer_number({$urandom(), $urandom()}, b[4:0], 1'(b % 2));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 30) holdoff_req = 1'b1;
            quiet = (n >= 140 && n < 200);
            r = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(3, 16));
            offer_number(pick_value(), r, 1'($urandom_range(0, 1)));
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
